### design/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list core: beat formats of the
// command and result channels, command codes and the cell control word.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [1:0] {
    CMD_HEAD   = 2'd0,
    CMD_TAIL   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     last;
    logic                     empty_res;
    logic                     dropped;
  } res_beat_t;

  // The operation that every cell of the chain carries out.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_LOAD_TAIL,
    OP_CLOSE_GAP,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         index;
  } cell_ctl_t;

endpackage

### design/indexed_list_insert_remove_core.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core
// Ordered list of up to CAPACITY signed 32-bit values with insert at front,
// append at back and remove at position; the whole list is read out after
// every command.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, cell 0 being the front. A
// command beat is applied to the chain in the cycle it is accepted: an insert
// at the front shifts every cell one place to the back, an append loads the
// cell just past the last element, and a remove pulls every cell at or after
// the position one place forward. The list is then read out by rotating the
// chain toward the front once per step for CAPACITY steps, taking the front
// cell as a result beat while the step is below the element count, so the
// chain ends up back in its original order. A result beat other than the
// final one of its command that sits stalled holds up the readout, since
// the next beat cannot be loaded until it leaves; a stall on the final beat
// does not hold off the next command, only the first beat of its readout.
// No command is taken until the readout is complete. An empty list gives
// one beat with element zero and empty_res set. An insert into a full list
// leaves the list untouched and sets dropped on every result beat of that
// command. A remove whose position is not below the count, and the unused
// command code, change nothing but still produce the full readout.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_core #(
  parameter int CAPACITY = ilir_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ilir_pkg::cmd_beat_t cmd_data,
  output logic                res_valid,
  input  logic                res_stall,
  output ilir_pkg::res_beat_t res_data
);
  import ilir_pkg::*;

  // Count width holds CAPACITY itself; the step counter shares it.
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL      = CW'(CAPACITY);
  localparam logic [CW-1:0] LAST_STEP = CW'(CAPACITY - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   step;
  logic            drop;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  logic accept;
  logic full;
  logic pos_ok;
  logic want_emit;
  logic slot_free;
  logic advance;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (count == FULL);
  assign pos_ok    = CMP_W'(cmd_data.position) < CMP_W'(count);

  // A step emits when it covers a stored element, or when the list is empty
  // and this is the single marker beat.
  assign want_emit = (step < count) || ((count == '0) && (step == '0));
  assign slot_free = !res_valid || !res_stall;
  assign advance   = (state == ST_EMIT) && (!want_emit || slot_free);

  // Control word shared by all cells. The tail index is the current count,
  // which always fits the position width for the supported sizes.
  always_comb begin
    ctl.op    = OP_HOLD;
    ctl.value = cmd_data.value;
    ctl.index = cmd_data.position;
    if (accept) begin
      case (cmd_data.cmd)
        CMD_HEAD: begin
          if (!full) begin
            ctl.op = OP_PUSH_FRONT;
          end
        end
        CMD_TAIL: begin
          if (!full) begin
            ctl.op    = OP_LOAD_TAIL;
            ctl.index = POS_W'(count);
          end
        end
        CMD_REMOVE: begin
          if (pos_ok) begin
            ctl.op = OP_CLOSE_GAP;
          end
        end
        default: ctl.op = OP_HOLD;
      endcase
    end else if (advance) begin
      ctl.op = OP_ROTATE;
    end
  end

  // The chain: each cell sees its front neighbor on the left and its back
  // neighbor on the right. The front cell takes the new value from the left,
  // and the back cell wraps around to the front for the readout rotation.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (g == 0) begin : g_front
      assign left_in = cmd_data.value;
    end else begin : g_mid
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_back
      assign right_in = cell_data[0];
    end else begin : g_inner
      assign right_in = cell_data[g+1];
    end
    ilir_cell #(
      .IDX(g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_left (left_in),
      .from_right(right_in),
      .data      (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      drop      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EMIT;
            step  <= '0;
            drop  <= 1'b0;
            case (cmd_data.cmd)
              CMD_HEAD, CMD_TAIL: begin
                if (full) begin
                  drop <= 1'b1;
                end else begin
                  count <= count + CW'(1);
                end
              end
              CMD_REMOVE: begin
                if (pos_ok) begin
                  count <= count - CW'(1);
                end
              end
              default: count <= count;
            endcase
          end
        end
        ST_EMIT: begin
          if (advance) begin
            if (want_emit) begin
              res_valid          <= 1'b1;
              res_data.element   <= (count == '0) ? '0 : cell_data[0];
              res_data.last      <= (count == '0) || (step + CW'(1) == count);
              res_data.empty_res <= (count == '0);
              res_data.dropped   <= drop;
            end
            step <= step + CW'(1);
            if (step == LAST_STEP) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The element count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("element count above capacity");

  // An insert into a full list leaves the count unchanged.
  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (cmd_data.cmd == CMD_HEAD || cmd_data.cmd == CMD_TAIL))
      |=> (count == FULL))
    else $error("insert into full list changed the count");

  // An empty-list beat is always the final beat of its command.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.empty_res) |-> res_data.last)
    else $error("empty result beat not marked last");

  // After a command is taken the block holds off further commands.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> cmd_stall)
    else $error("command side not stalled during readout");

endmodule

### design/ilir_cell.sv
// ----------------------------------------------------------------------------
// ilir_cell
// One list entry of the chain. It keeps its value, takes its left or right
// neighbor's value, or loads a new value, as the shared control word says.
// ----------------------------------------------------------------------------
module ilir_cell #(
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  ilir_pkg::cell_ctl_t                 ctl,
  input  logic signed [ilir_pkg::DATA_W-1:0]  from_left,
  input  logic signed [ilir_pkg::DATA_W-1:0]  from_right,
  output logic signed [ilir_pkg::DATA_W-1:0]  data
);
  import ilir_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      OP_HOLD:       data_next = data;
      OP_PUSH_FRONT: data_next = from_left;
      OP_LOAD_TAIL: begin
        if (ctl.index == MY_IDX) begin
          data_next = ctl.value;
        end
      end
      OP_CLOSE_GAP: begin
        if (MY_IDX >= ctl.index) begin
          data_next = from_right;
        end
      end
      OP_ROTATE:     data_next = from_right;
      default:       data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
